// ----- design/point_iso_rotate_project_defines.svh -----
// Assertion macros for the checker file of the point projection block.
// Each macro samples on the rising edge of clk and is off while rst_n is low.
`ifndef POINT_ISO_ROTATE_PROJECT_DEFINES_SVH
`define POINT_ISO_ROTATE_PROJECT_DEFINES_SVH

// Same-cycle implication.
`define PIR_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PIR_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/pir_pkg.sv -----
`default_nettype none

package pir_pkg;

    localparam int SCREEN_WIDTH  = 1920;
    localparam int SCREEN_HEIGHT = 1080;
    localparam int MENU_COLUMNS  = 256;
    localparam int TOP_MARGIN    = 100;
    localparam int X_CENTER      = (SCREEN_WIDTH - MENU_COLUMNS) / 2 + MENU_COLUMNS;

    // Q1.14 cosine of 30 degrees
    localparam logic signed [15:0] ISO_COS = 16'sd14189;

    // Number of register stages from input to output register
    localparam int PIPE_DEPTH = 11;

    // Configuration register indexes
    localparam logic [7:0] REG_ZOOM       = 8'd0;
    localparam logic [7:0] REG_Z_SCALE    = 8'd1;
    localparam logic [7:0] REG_ISO_ENABLE = 8'd2;
    localparam logic [7:0] REG_ROT_X_TRIG = 8'd3;
    localparam logic [7:0] REG_ROT_Y_TRIG = 8'd4;
    localparam logic [7:0] REG_ROT_Z_TRIG = 8'd5;
    localparam logic [7:0] REG_VIEW_OFFS  = 8'd6;
    localparam logic [7:0] REG_MAP_SIZE   = 8'd7;

    // Reset values
    localparam logic [7:0]  ZOOM_RST    = 8'd20;
    localparam logic [15:0] Z_SCALE_RST = 16'd256;
    localparam logic [31:0] TRIG_RST    = 32'h4000_0000;

    // Load enables of the two stages of one rotation unit
    typedef struct packed {
        logic prod_en;
        logic sum_en;
    } pir_step_t;

    // Divide by 16384 with truncation toward zero
    function automatic logic signed [31:0] q14_trunc(input logic signed [47:0] n);
        logic signed [47:0] adj;
        adj = n + (n[47] ? 48'sd16383 : 48'sd0);
        return adj[45:14];
    endfunction

    // Clamp to 24-bit signed range
    function automatic logic [23:0] sat24(input logic signed [33:0] v);
        logic [23:0] r;
        if (v > 34'sd8388607)
        begin
            r = 24'h7F_FFFF;
        end
        else if (v < -34'sd8388608)
        begin
            r = 24'h80_0000;
        end
        else
        begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/pir_rot.sv -----
`default_nettype none

// One axis rotation: p' = (p*c + q*s)/2^14, q' = (q*c - p*s)/2^14.
// Stage one registers the four products, stage two the truncated sums.
module pir_rot
    import pir_pkg::*;
(
    input  wire  logic               clk,
    input  wire  pir_step_t          step,
    input  wire  logic [31:0]        trig,
    input  wire  logic signed [31:0] p_in,
    input  wire  logic signed [31:0] q_in,
    input  wire  logic signed [31:0] pass_in,
    output logic signed [31:0]       p_out,
    output logic signed [31:0]       q_out,
    output logic signed [31:0]       pass_out
);

    logic signed [15:0] cos_v;
    logic signed [15:0] sin_v;

    logic signed [47:0] pc_reg;
    logic signed [47:0] qs_reg;
    logic signed [47:0] qc_reg;
    logic signed [47:0] ps_reg;
    logic signed [31:0] pass1_reg;

    logic signed [31:0] p_reg;
    logic signed [31:0] q_reg;
    logic signed [31:0] pass2_reg;

    logic signed [31:0] p_next;
    logic signed [31:0] q_next;

    assign cos_v = trig[31:16];
    assign sin_v = trig[15:0];

    always_ff @(posedge clk)
    begin
        if (step.prod_en)
        begin
            pc_reg    <= 48'(p_in) * 48'(cos_v);
            qs_reg    <= 48'(q_in) * 48'(sin_v);
            qc_reg    <= 48'(q_in) * 48'(cos_v);
            ps_reg    <= 48'(p_in) * 48'(sin_v);
            pass1_reg <= pass_in;
        end
    end

    always_comb
    begin
        p_next = q14_trunc(pc_reg + qs_reg);
        q_next = q14_trunc(qc_reg - ps_reg);
    end

    always_ff @(posedge clk)
    begin
        if (step.sum_en)
        begin
            p_reg     <= p_next;
            q_reg     <= q_next;
            pass2_reg <= pass1_reg;
        end
    end

    assign p_out    = p_reg;
    assign q_out    = q_reg;
    assign pass_out = pass2_reg;

endmodule

`default_nettype wire

// ----- design/point_iso_rotate_project.sv -----
// Point projection: map point (col, row, height) in, screen position and depth out.
// Input stream s_*: one point per request, 40-bit tdata. Output stream m_*: one
// result per point, 72-bit tdata, in the order the points came in.
// Configuration: write cfg_index/cfg_data with cfg_valid; cfg_ready is always high.
// Write registers only while no point is in flight. Unknown indexes are ignored.
// Throughput: one point per cycle while m_tready is high; the pipeline depth is set
// by the multiply chain (scale, isometric multiply and three two-stage rotation
// units), each multiply followed by a register.
// Every stage holds a valid bit and loads when it is empty or its successor loads,
// so bubbles collapse. When m_tready is low the output register holds its result
// and the stages behind it keep filling; s_tready drops only once all 11 stages
// hold a point. Nothing is lost or repeated across a stall.
// Reset (rst_n low, asynchronous) empties the pipeline and loads the register
// defaults: zoom 20, z_scale 1.0, isometric view, identity rotations, zero
// offsets and zero map size.
`default_nettype none

module point_iso_rotate_project
    import pir_pkg::*;
(
    input  wire  logic        clk,
    input  wire  logic        rst_n,
    // configuration write channel
    input  wire  logic        cfg_valid,
    output logic              cfg_ready,
    input  wire  logic [7:0]  cfg_index,
    input  wire  logic [31:0] cfg_data,
    // input points
    input  wire  logic        s_tvalid,
    output logic              s_tready,
    input  wire  logic [39:0] s_tdata,   // col[9:0], row[19:10], height[35:20], zero pad
    // projected points
    output logic              m_tvalid,
    input  wire  logic        m_tready,
    output logic [71:0]       m_tdata    // screen_x[23:0], screen_y[47:24], depth[71:48]
);

    // ---------------------------------------------------------------- config
    logic [7:0]  zoom_reg;
    logic [15:0] z_scale_reg;
    logic        iso_en_reg;
    logic [31:0] rot_x_reg;
    logic [31:0] rot_y_reg;
    logic [31:0] rot_z_reg;
    logic [31:0] offs_reg;
    logic [31:0] map_size_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zoom_reg     <= ZOOM_RST;
            z_scale_reg  <= Z_SCALE_RST;
            iso_en_reg   <= 1'b1;
            rot_x_reg    <= TRIG_RST;
            rot_y_reg    <= TRIG_RST;
            rot_z_reg    <= TRIG_RST;
            offs_reg     <= '0;
            map_size_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ZOOM:       zoom_reg     <= cfg_data[7:0];
                REG_Z_SCALE:    z_scale_reg  <= cfg_data[15:0];
                REG_ISO_ENABLE: iso_en_reg   <= cfg_data[0];
                REG_ROT_X_TRIG: rot_x_reg    <= cfg_data;
                REG_ROT_Y_TRIG: rot_y_reg    <= cfg_data;
                REG_ROT_Z_TRIG: rot_z_reg    <= cfg_data;
                REG_VIEW_OFFS:  offs_reg     <= cfg_data;
                REG_MAP_SIZE:   map_size_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Vertical centring term, refreshed every cycle from the live registers.
    // Map height times zoom is non-negative, so the halving is a plain shift.
    logic [23:0]        map_hz;
    logic [24:0]        ctr_y_sum;
    logic signed [25:0] ctr_y_reg;
    logic signed [25:0] ctr_y_next;

    always_comb
    begin
        map_hz     = 24'(map_size_reg[15:0] * zoom_reg);
        ctr_y_sum  = 25'(map_hz) + 25'(SCREEN_HEIGHT);
        ctr_y_next = $signed({2'b00, ctr_y_sum[24:1]}) - 26'sd100;
    end

    always_ff @(posedge clk)
    begin
        ctr_y_reg <= ctr_y_next;
    end

    // ---------------------------------------------------------- flow control
    logic [PIPE_DEPTH-1:0] v_reg;
    logic [PIPE_DEPTH-1:0] v_next;
    logic [PIPE_DEPTH-1:0] en;

    // A stage loads when empty or when the stage after it loads
    always_comb
    begin
        en[PIPE_DEPTH-1] = !v_reg[PIPE_DEPTH-1] || m_tready;
        for (int k = PIPE_DEPTH - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
        for (int k = 0; k < PIPE_DEPTH; k++)
        begin
            if (en[k])
            begin
                v_next[k] = (k == 0) ? s_tvalid : v_reg[(k == 0) ? 0 : k - 1];
            end
            else
            begin
                v_next[k] = v_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[PIPE_DEPTH-1];

    // ------------------------------------------------- stage 1: zoom products
    logic [9:0]         in_col;
    logic [9:0]         in_row;
    logic signed [15:0] in_height;

    logic [17:0]        colz_reg;
    logic [17:0]        rowz_reg;
    logic [23:0]        mapwz_reg;
    logic [23:0]        maphz_reg;
    logic signed [31:0] hz_reg;

    assign in_col    = s_tdata[9:0];
    assign in_row    = s_tdata[19:10];
    assign in_height = s_tdata[35:20];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            colz_reg  <= 18'(in_col * zoom_reg);
            rowz_reg  <= 18'(in_row * zoom_reg);
            mapwz_reg <= 24'(map_size_reg[31:16] * zoom_reg);
            maphz_reg <= 24'(map_size_reg[15:0] * zoom_reg);
            hz_reg    <= 32'(in_height) * 32'($signed(z_scale_reg));
        end
    end

    // --------------------------------------------- stage 2: centre, scale z
    logic signed [25:0] x0_reg;
    logic signed [25:0] y0_reg;
    logic signed [23:0] z0_reg;
    logic signed [25:0] x0_next;
    logic signed [25:0] y0_next;
    logic signed [31:0] hz_adj;

    always_comb
    begin
        x0_next = $signed({8'b0, colz_reg}) - $signed({3'b0, mapwz_reg[23:1]});
        y0_next = $signed({8'b0, rowz_reg}) - $signed({3'b0, maphz_reg[23:1]});
        // truncate toward zero on the divide by 256
        hz_adj  = hz_reg + (hz_reg[31] ? 32'sd255 : 32'sd0);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            x0_reg <= x0_next;
            y0_reg <= y0_next;
            z0_reg <= hz_adj[31:8];
        end
    end

    // ------------------------------------------ stage 3: isometric multiply
    logic signed [26:0] iso_diff;
    logic signed [41:0] iso_prod_reg;
    logic signed [27:0] iso_sum_reg;
    logic signed [27:0] iso_sum_next;
    logic signed [25:0] x0d_reg;
    logic signed [25:0] y0d_reg;
    logic signed [23:0] z0d_reg;

    always_comb
    begin
        iso_diff     = 27'(x0_reg) - 27'(y0_reg);
        // (x+y)*sin30 - z in Q14, divided by 2^14, is ((x+y) - 2z) / 2
        iso_sum_next = 28'(x0_reg) + 28'(y0_reg) - (28'(z0_reg) <<< 1);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            iso_prod_reg <= 42'(iso_diff) * 42'(ISO_COS);
            iso_sum_reg  <= iso_sum_next;
            x0d_reg      <= x0_reg;
            y0d_reg      <= y0_reg;
            z0d_reg      <= z0_reg;
        end
    end

    // ------------------------------------------- stage 4: isometric select
    logic signed [27:0] half_adj;
    logic signed [31:0] xi_reg;
    logic signed [31:0] yi_reg;
    logic signed [31:0] zi_reg;
    logic signed [31:0] xi_next;
    logic signed [31:0] yi_next;

    always_comb
    begin
        half_adj = iso_sum_reg + $signed({27'b0, iso_sum_reg[27]});
        if (iso_en_reg)
        begin
            xi_next = q14_trunc(48'(iso_prod_reg));
            yi_next = 32'($signed(half_adj[27:1]));
        end
        else
        begin
            xi_next = 32'(x0d_reg);
            yi_next = 32'(y0d_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            xi_reg <= xi_next;
            yi_reg <= yi_next;
            zi_reg <= 32'(z0d_reg);
        end
    end

    // --------------------------------------------- stages 5..10: rotations
    pir_step_t          step_x;
    pir_step_t          step_y;
    pir_step_t          step_z;
    logic signed [31:0] y1;
    logic signed [31:0] z1;
    logic signed [31:0] x1;
    logic signed [31:0] x2;
    logic signed [31:0] z2;
    logic signed [31:0] y2;
    logic signed [31:0] y3;
    logic signed [31:0] x3;
    logic signed [31:0] z3;

    assign step_x = '{prod_en: en[4], sum_en: en[5]};
    assign step_y = '{prod_en: en[6], sum_en: en[7]};
    assign step_z = '{prod_en: en[8], sum_en: en[9]};

    // about x: (y, z)
    pir_rot u_rot_x (
        .clk      (clk),
        .step     (step_x),
        .trig     (rot_x_reg),
        .p_in     (yi_reg),
        .q_in     (zi_reg),
        .pass_in  (xi_reg),
        .p_out    (y1),
        .q_out    (z1),
        .pass_out (x1)
    );

    // about y: (x, z)
    pir_rot u_rot_y (
        .clk      (clk),
        .step     (step_y),
        .trig     (rot_y_reg),
        .p_in     (x1),
        .q_in     (z1),
        .pass_in  (y1),
        .p_out    (x2),
        .q_out    (z2),
        .pass_out (y2)
    );

    // about z: p = y, q = x gives x' = x*c - y*s and y' = x*s + y*c
    pir_rot u_rot_z (
        .clk      (clk),
        .step     (step_z),
        .trig     (rot_z_reg),
        .p_in     (y2),
        .q_in     (x2),
        .pass_in  (z2),
        .p_out    (y3),
        .q_out    (x3),
        .pass_out (z3)
    );

    // ------------------------------------ stage 11: offsets, clamp, output
    logic signed [33:0] fx;
    logic signed [33:0] fy;
    logic [71:0]        out_reg;
    logic [71:0]        out_next;

    always_comb
    begin
        fx = 34'(x3) + 34'($signed(offs_reg[31:16])) + 34'(X_CENTER);
        fy = 34'(y3) + 34'($signed(offs_reg[15:0])) + 34'(ctr_y_reg);
        out_next = {sat24(34'(z3)), sat24(fy), sat24(fx)};
    end

    always_ff @(posedge clk)
    begin
        if (en[10])
        begin
            out_reg <= out_next;
        end
    end

    assign m_tdata = out_reg;

endmodule

`default_nettype wire

// ----- design/pir_checker.sv -----
`default_nettype none

`include "point_iso_rotate_project_defines.svh"

module pir_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [71:0] m_tdata,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready
);

    // stalled result holds
    `PIR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output changed under stall")

    // input backs up only when every stage is full and the sink stalls
    `PIR_ASSERT_SAME(a_full_stall, !s_tready, m_tvalid && !m_tready, "input stalled with room in pipeline")

    // a ready sink lets every stage advance
    `PIR_ASSERT_SAME(a_drain_ready, m_tready, s_tready, "input stalled while sink ready")

    // register writes are never refused
    `PIR_ASSERT_SAME(a_cfg_ready, cfg_valid, cfg_ready, "config write refused")

endmodule

bind point_iso_rotate_project pir_checker u_pir_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

`default_nettype wire

// ----- bench/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pir_pkg::*;

    // Fixed-point scales and output clamp limits of the projection math
    localparam longint Q14_ONE     = 16384;
    localparam longint ISO_SIN_Q14 = 8192;
    localparam longint OUT_HI      = 8388607;
    localparam longint OUT_LO      = -8388608;

    // Register indexes outside the map; writes to them must not change anything
    localparam logic [7:0] REG_UNUSED_LO = 8'd8;
    localparam logic [7:0] REG_UNUSED_HI = 8'hFF;

    // Run limits
    localparam int CYCLE_LIMIT   = 200000;
    localparam int REPORT_LIMIT  = 10;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_POINTS  = 130;

    // How the output side accepts results
    typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

    // One projected point as it leaves the block
    typedef struct packed {
        logic [23:0] dz;
        logic [23:0] sy;
        logic [23:0] sx;
    } screen_pt_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;    // col[9:0], row[19:10], height[35:20], zero pad
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;         // screen_x[23:0], screen_y[47:24], depth[71:48]

    // Shadow copy of the configuration registers
    logic [7:0]  zoom_r     = ZOOM_RST;
    logic [15:0] z_scale_r  = Z_SCALE_RST;
    logic        iso_r      = 1'b1;
    logic [31:0] rot_x_r    = TRIG_RST;
    logic [31:0] rot_y_r    = TRIG_RST;
    logic [31:0] rot_z_r    = TRIG_RST;
    logic [31:0] offsets_r  = '0;
    logic [31:0] map_size_r = '0;

    // Projected points still owed by the block, oldest first
    screen_pt_t pending_screen_pts[$];

    int       points_sent = 0;
    int       directed_points = 0;
    int       reg_writes = 0;
    int       results_seen = 0;
    int       saturated_fields = 0;
    int       fail_count = 0;
    int       cycle_count = 0;

    // Sender pacing: bursts of random length, each after a random gap bounded by gap_max
    int       burst_left = 0;
    int       gap_max = 0;

    // Receiver pacing; rx_hold_left forces a long stall counted down per cycle
    rx_mode_t    rx_mode = RX_ALWAYS;
    int          rx_hold_left = 0;
    logic [15:0] rx_pat = 16'b1011_0111_0010_1101;

    point_iso_rotate_project dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still owed",
                     cycle_count, pending_screen_pts.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic longint sx16(input logic [15:0] v);
        return longint'($signed(v));
    endfunction

    function automatic logic [23:0] clamp24(input longint v);
        logic [23:0] r;
        if (v > OUT_HI)
        begin
            r = 24'h7F_FFFF;
        end
        else if (v < OUT_LO)
        begin
            r = 24'h80_0000;
        end
        else
        begin
            r = v[23:0];
        end
        return r;
    endfunction

    // Rotate the pair (a, b) by a packed cos/sin word, truncating toward zero.
    // Flip the sine for the z axis, whose sense is opposite to the x and y axes.
    function automatic void rotate_pair(input longint a, input longint b,
                                        input logic [31:0] trig, input bit flip,
                                        output longint na, output longint nb);
        longint c;
        longint s;
        c = sx16(trig[31:16]);
        s = sx16(trig[15:0]);
        if (flip)
        begin
            s = -s;
        end
        na = (a * c + b * s) / Q14_ONE;
        nb = (b * c - a * s) / Q14_ONE;
    endfunction

    // Screen position and depth of one map point under the current registers
    function automatic screen_pt_t project_point(input logic [9:0] col, input logic [9:0] row,
                                                 input logic [15:0] height);
        longint zm;
        longint mw;
        longint mh;
        longint x;
        longint y;
        longint z;
        longint t;
        screen_pt_t p;
        zm = longint'(zoom_r);
        mw = longint'(map_size_r[31:16]);
        mh = longint'(map_size_r[15:0]);
        x = longint'(col) * zm - (mw * zm) / 2;
        y = longint'(row) * zm - (mh * zm) / 2;
        z = (sx16(height) * sx16(z_scale_r)) / 256;
        if (iso_r)
        begin
            t = x;
            x = ((t - y) * longint'(ISO_COS)) / Q14_ONE;
            y = ((t + y) * ISO_SIN_Q14 - z * Q14_ONE) / Q14_ONE;
        end
        rotate_pair(y, z, rot_x_r, 1'b0, y, z);
        rotate_pair(x, z, rot_y_r, 1'b0, x, z);
        rotate_pair(x, y, rot_z_r, 1'b1, x, y);
        y = y + sx16(offsets_r[15:0]) + (SCREEN_HEIGHT + mh * zm) / 2 - TOP_MARGIN;
        x = x + sx16(offsets_r[31:16]) + X_CENTER;
        p.sx = clamp24(x);
        p.sy = clamp24(y);
        p.dz = clamp24(z);
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Output side: stall pattern and result checking
    // ------------------------------------------------------------------

    // Drive m_tready at the falling edge; a pending hold-off wins over the mode
    always @(negedge clk)
    begin
        if (rx_hold_left > 0)
        begin
            m_tready <= 1'b0;
            rx_hold_left--;
        end
        else
        begin
            case (rx_mode)
                RX_ALWAYS:  m_tready <= 1'b1;
                RX_RANDOM:  m_tready <= ($urandom_range(0, 3) != 0);
                default:
                begin
                    m_tready <= rx_pat[0];
                    rx_pat = {rx_pat[0], rx_pat[15:1]};
                end
            endcase
        end
    end

    // Compare every result leaving the block with the oldest owed point
    always @(posedge clk)
    begin : check_results
        screen_pt_t got;
        screen_pt_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            results_seen++;
            if (pending_screen_pts.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                begin
                    $display("%0t: result with nothing owed: x %0d y %0d depth %0d", $realtime,
                             $signed(got.sx), $signed(got.sy), $signed(got.dz));
                end
            end
            else
            begin
                want = pending_screen_pts.pop_front();
                if (want.sx == 24'h7F_FFFF || want.sx == 24'h80_0000)
                    saturated_fields++;
                if (want.sy == 24'h7F_FFFF || want.sy == 24'h80_0000)
                    saturated_fields++;
                if (want.dz == 24'h7F_FFFF || want.dz == 24'h80_0000)
                    saturated_fields++;
                if (got.sx !== want.sx || got.sy !== want.sy || got.dz !== want.dz)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                    begin
                        $display("%0t: result %0d wrong: x %0d/%0d y %0d/%0d depth %0d/%0d",
                                 $realtime, results_seen,
                                 $signed(want.sx), $signed(got.sx),
                                 $signed(want.sy), $signed(got.sy),
                                 $signed(want.dz), $signed(got.dz));
                        $display("    (expected/actual, raw %h / %h)", want, got);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side helpers
    // ------------------------------------------------------------------

    // Offer one point; when gap_max is nonzero, insert a random gap at the start of each burst
    task automatic send_point(input logic [9:0] col, input logic [9:0] row,
                              input logic [15:0] height);
        int gap;
        if (burst_left == 0)
        begin
            if (gap_max > 0)
            begin
                gap = $urandom_range(1, gap_max);
                repeat (gap)
                begin
                    @(negedge clk);
                    s_tvalid <= 1'b0;
                    s_tdata  <= {$urandom, 8'($urandom)};
                end
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, height, row, col};
        do @(posedge clk); while (!s_tready);
        pending_screen_pts.push_back(project_point(col, row, height));
        points_sent++;
    endtask

    // Random point; now and then pin a field to one of its extremes
    task automatic send_random_point;
        logic [9:0]  col;
        logic [9:0]  row;
        logic [15:0] height;
        col    = 10'($urandom);
        row    = 10'($urandom);
        height = 16'($urandom);
        case ($urandom_range(0, 11))
            0: col = '1;
            1: row = '0;
            2: height = 16'h8000;
            3: height = 16'h7FFF;
            default: ;
        endcase
        send_point(col, row, height);
    endtask

    // Write one register and mirror the write in the shadow copy
    task automatic write_reg(input logic [7:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_ZOOM:       zoom_r     = data[7:0];
            REG_Z_SCALE:    z_scale_r  = data[15:0];
            REG_ISO_ENABLE: iso_r      = data[0];
            REG_ROT_X_TRIG: rot_x_r    = data;
            REG_ROT_Y_TRIG: rot_y_r    = data;
            REG_ROT_Z_TRIG: rot_z_r    = data;
            REG_VIEW_OFFS:  offsets_r  = data;
            REG_MAP_SIZE:   map_size_r = data;
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drop the input, wait for every owed result, then let the pipeline settle
    task automatic drain_pipeline;
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_screen_pts.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 4) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic send_corner_points;
        send_point(10'd0,    10'd0,    16'h0000);
        send_point(10'h3FF,  10'h3FF,  16'h7FFF);
        send_point(10'd0,    10'h3FF,  16'h8000);
        send_point(10'h3FF,  10'd0,    16'hFFFF);
        directed_points += 4;
    endtask

    // Rotation word: identity, a random in-range cos/sin pair, raw noise, an extreme or 45 degrees
    function automatic logic [31:0] pick_trig;
        int c;
        int s;
        logic [31:0] w;
        case ($urandom_range(0, 4))
            0: w = TRIG_RST;
            1:
            begin
                c = int'($urandom_range(0, 32768)) - 16384;
                s = int'($urandom_range(0, 32768)) - 16384;
                w = {c[15:0], s[15:0]};
            end
            2: w = $urandom;
            3:
            begin
                case ($urandom_range(0, 3))
                    0: w = 32'h7FFF_7FFF;
                    1: w = 32'h8000_8000;
                    2: w = 32'h8000_7FFF;
                    default: w = 32'h0000_4000;
                endcase
            end
            default: w = 32'h2D41_2D41;
        endcase
        return w;
    endfunction

    // Load a fresh random setting into every register
    task automatic randomize_setup;
        logic [31:0] d;
        d = $urandom;
        case ($urandom_range(0, 7))
            0: d[7:0] = 8'h00;
            1: d[7:0] = 8'hFF;
            2, 3, 4: d[7:0] = 8'($urandom_range(1, 8));
            default: ;
        endcase
        write_reg(REG_ZOOM, d);
        d = $urandom;
        case ($urandom_range(0, 5))
            0: d[15:0] = Z_SCALE_RST;
            1: d[15:0] = 16'h8000;
            2: d[15:0] = 16'h7FFF;
            default: ;
        endcase
        write_reg(REG_Z_SCALE, d);
        write_reg(REG_ISO_ENABLE, $urandom);
        write_reg(REG_ROT_X_TRIG, pick_trig());
        write_reg(REG_ROT_Y_TRIG, pick_trig());
        write_reg(REG_ROT_Z_TRIG, pick_trig());
        write_reg(REG_VIEW_OFFS, $urandom);
        if ($urandom_range(0, 2) == 0)
            write_reg(REG_MAP_SIZE, $urandom);
        else
            write_reg(REG_MAP_SIZE, {16'($urandom_range(0, 1100)), 16'($urandom_range(0, 1100))});
        if ($urandom_range(0, 3) == 0)
            write_reg(8'($urandom_range(8, 255)), $urandom);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Corner points under the reset setting: isometric view, identity rotations
    task automatic test_reset_setting;
        gap_max = 2;
        rx_mode = RX_RANDOM;
        send_corner_points();
        drain_pipeline();
    endtask

    // Extreme register values, zoom zero, parallel view and ignored writes
    task automatic test_register_extremes;
        // largest zoom and map, strongest trig words: drives most outputs into saturation
        write_reg(REG_ZOOM, 32'h0000_00FF);
        write_reg(REG_Z_SCALE, 32'h0000_7FFF);
        write_reg(REG_ISO_ENABLE, 32'h0000_0001);
        write_reg(REG_ROT_X_TRIG, 32'h7FFF_7FFF);
        write_reg(REG_ROT_Y_TRIG, 32'h7FFF_7FFF);
        write_reg(REG_ROT_Z_TRIG, 32'h8000_8000);
        write_reg(REG_VIEW_OFFS, 32'h7FFF_7FFF);
        write_reg(REG_MAP_SIZE, 32'hFFFF_FFFF);
        send_corner_points();
        drain_pipeline();

        // zoom zero and parallel view, both set with junk in the upper bits
        write_reg(REG_ZOOM, 32'hFFFF_FF00);
        write_reg(REG_Z_SCALE, 32'hABCD_8000);
        write_reg(REG_ISO_ENABLE, 32'hFFFF_FFFE);
        write_reg(REG_ROT_X_TRIG, 32'h8000_7FFF);
        write_reg(REG_ROT_Y_TRIG, 32'h0000_4000);
        write_reg(REG_ROT_Z_TRIG, 32'h8000_8000);
        write_reg(REG_VIEW_OFFS, 32'h8000_8000);
        write_reg(REG_MAP_SIZE, 32'h0000_0000);
        send_corner_points();
        drain_pipeline();

        // small sane view: unit zoom, small map, quarter turn about z
        write_reg(REG_ZOOM, 32'h0000_0001);
        write_reg(REG_Z_SCALE, {16'h0000, Z_SCALE_RST});
        write_reg(REG_ISO_ENABLE, 32'h0000_0001);
        write_reg(REG_ROT_X_TRIG, TRIG_RST);
        write_reg(REG_ROT_Y_TRIG, TRIG_RST);
        write_reg(REG_ROT_Z_TRIG, 32'h0000_4000);
        write_reg(REG_VIEW_OFFS, 32'h0000_0000);
        write_reg(REG_MAP_SIZE, {16'd20, 16'd11});
        send_corner_points();
        drain_pipeline();

        // unmapped indexes must leave the setting above untouched
        write_reg(REG_UNUSED_LO, 32'hFFFF_FFFF);
        write_reg(REG_UNUSED_HI, 32'h0000_0000);
        send_corner_points();
        drain_pipeline();
    endtask

    // Phases of random points, each under a new random setting and pacing.
    // The first phase runs at full rate on both sides.
    task automatic test_random_traffic;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            randomize_setup();
            if (phase == 0)
            begin
                gap_max = 0;
                rx_mode = RX_ALWAYS;
            end
            else
            begin
                gap_max = $urandom_range(1, 8);
                rx_mode = rx_mode_t'($urandom_range(0, 2));
            end
            repeat (PHASE_POINTS) send_random_point();
            drain_pipeline();
        end
    endtask

    // Hold the output off long enough to fill every stage and stall the input,
    // then pause the sender until nothing is owed and resume.
    task automatic test_backpressure;
        randomize_setup();
        gap_max = 0;
        rx_mode = RX_ALWAYS;
        @(posedge clk);
        rx_hold_left = 200;
        repeat (40) send_random_point();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_screen_pts.size() != 0)
            @(posedge clk);
        rx_mode = RX_RANDOM;
        gap_max = 3;
        repeat (20) send_random_point();
        drain_pipeline();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_setting();
        test_register_extremes();
        test_random_traffic();
        test_backpressure();

        $display("Sent %0d points (%0d directed) over %0d register writes in %0d cycles;",
                 points_sent, directed_points, reg_writes, cycle_count);
        $display("checked %0d results, %0d saturated fields, %0d failures.",
                 results_seen, saturated_fields, fail_count);
        if (fail_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
